FILE: design/lag_pkg.sv
package lag_pkg;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic mul;
    logic out_load;
  } lag_cmd_t;

  typedef struct packed {
    logic special;
    logic gcd_eq;
    logic div_last;
  } lag_status_t;

  localparam int unsigned OperandPortWidth = 16;
  localparam int unsigned LcmWidth         = 32;
  localparam int unsigned GcdWidth         = 16;

endpackage

FILE: design/lag_in_if.sv
interface lag_in_if import lag_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [OperandPortWidth-1:0] operand_a;
  logic [OperandPortWidth-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

FILE: design/lag_out_if.sv
interface lag_out_if import lag_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LcmWidth-1:0] lcm_value;
  logic [GcdWidth-1:0] gcd_value;
  logic                div_error;

  modport source (output valid, output lcm_value, output gcd_value, output div_error,
                  input ready);
  modport sink   (input valid, input lcm_value, input gcd_value, input div_error,
                  output ready);
endinterface

FILE: design/lcm_and_gcd_unit.sv
// Channel   Dir  Fields                                Handshake
// in_ch     in   operand_a[15:0], operand_b[15:0]      valid/ready
// out_ch    out  lcm_value[31:0], gcd_value[15:0],     valid/ready
//                div_error
// One item at a time. An item with a zero operand skips the gcd loop, the divider and
// the multiply and goes straight to writeback. Otherwise it passes the binary gcd loop,
// the restoring divider and one multiply, in that order, before writeback.
// Reset is synchronous, active low; it clears the controller and the output valid.
// A new item is taken while a result waits on out_ch; it holds before writeback.
module lcm_and_gcd_unit import lag_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  lag_in_if.sink           in_ch,
  lag_out_if.source        out_ch
);

  lag_cmd_t    cmd;
  lag_status_t status;

  lag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lag_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk       (clk),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .cmd       (cmd),
    .status    (status),
    .lcm_value (out_ch.lcm_value),
    .gcd_value (out_ch.gcd_value),
    .div_error (out_ch.div_error)
  );

endmodule

FILE: design/lag_ctrl.sv
module lag_ctrl import lag_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  lag_status_t status,
  output lag_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (status.special) begin
          state_nxt = S_WB;
        end else if (status.gcd_eq) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/lag_dp.sv
module lag_dp import lag_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                        clk,
  input  logic [OperandPortWidth-1:0] operand_a,
  input  logic [OperandPortWidth-1:0] operand_b,
  input  lag_cmd_t                    cmd,
  output lag_status_t                 status,
  output logic [LcmWidth-1:0]         lcm_value,
  output logic [GcdWidth-1:0]         gcd_value,
  output logic                        div_error
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned KW = $clog2(W);

  logic [W-1:0]    a_r, b_r;
  logic [W-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [W-1:0]    g_r;
  logic [W-1:0]    q_r, q_nxt;
  logic [W-1:0]    rem_r, rem_nxt;
  logic [KW-1:0]   cnt_r;
  logic [2*W-1:0]  prod_r;
  logic [LcmWidth-1:0] lcm_r;
  logic [GcdWidth-1:0] gcd_r;
  logic            err_r;
  logic [W:0]      trial;
  logic [W-1:0]    big;

  assign status.special  = (a_r == '0) || (b_r == '0);
  assign status.gcd_eq   = (x_r == y_r);
  assign status.div_last = (cnt_r == KW'(W - 1));

  assign lcm_value = lcm_r;
  assign gcd_value = gcd_r;
  assign div_error = err_r;

  assign big = (a_r > b_r) ? a_r : b_r;

  // binary gcd step; both stay nonzero until they meet
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    k_nxt = k_r;
    if (!x_r[0] && !y_r[0]) begin
      x_nxt = x_r >> 1;
      y_nxt = y_r >> 1;
      k_nxt = k_r + 1'b1;
    end else if (!x_r[0]) begin
      x_nxt = x_r >> 1;
    end else if (!y_r[0]) begin
      y_nxt = y_r >> 1;
    end else if (x_r > y_r) begin
      x_nxt = (x_r - y_r) >> 1;
    end else begin
      y_nxt = (y_r - x_r) >> 1;
    end
  end

  // restoring divide, one quotient bit per step
  always_comb begin
    trial = {rem_r, q_r[W-1]};
    if (trial >= {1'b0, g_r}) begin
      rem_nxt = W'(trial - {1'b0, g_r});
      q_nxt   = {q_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[W-1:0];
      q_nxt   = {q_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= W'(operand_a);
      b_r <= W'(operand_b);
      x_r <= W'(operand_a);
      y_r <= W'(operand_b);
      k_r <= '0;
    end
    if (cmd.gcd_step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      k_r <= k_nxt;
    end
    if (cmd.div_init) begin
      g_r   <= x_r << k_r;
      q_r   <= a_r;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.mul) begin
      prod_r <= (2*W)'(q_r) * (2*W)'(b_r);
    end
    if (cmd.out_load) begin
      if (status.special) begin
        lcm_r <= LcmWidth'(big);
        gcd_r <= '0;
        err_r <= (big == '0);
      end else begin
        lcm_r <= LcmWidth'(prod_r);
        gcd_r <= GcdWidth'(g_r);
        err_r <= 1'b0;
      end
    end
  end

endmodule

FILE: verif/lcm_gcd_checker.sv
module lcm_gcd_checker import lag_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lag_in_if    in_mon,
  lag_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OperandPortWidth-1:0] a;
    logic [OperandPortWidth-1:0] b;
    logic [LcmWidth-1:0]         lcm;
    logic [GcdWidth-1:0]         gcd;
    logic                        err;
  } lcm_gcd_t;

  lcm_gcd_t expected_q[$];
  int       mismatches = 0;

  function automatic lcm_gcd_t predict_lcm_gcd(input logic [OperandPortWidth-1:0] a,
                                              input logic [OperandPortWidth-1:0] b);
    logic [LcmWidth-1:0] x;
    logic [LcmWidth-1:0] y;
    logic [LcmWidth-1:0] r;
    lcm_gcd_t            res;
    res.a   = a;
    res.b   = b;
    res.err = 1'b0;
    if (a == '0 && b == '0) begin
      res.lcm = '0;
      res.gcd = '0;
      res.err = 1'b1;
    end else if (a == '0 || b == '0) begin
      res.lcm = (a > b) ? LcmWidth'(a) : LcmWidth'(b);
      res.gcd = '0;
    end else begin
      x = LcmWidth'(a);
      y = LcmWidth'(b);
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.lcm = (LcmWidth'(a) / x) * LcmWidth'(b);
      res.gcd = GcdWidth'(x);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    lcm_gcd_t exp_item;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        expected_q = {expected_q, predict_lcm_gcd(in_mon.operand_a, in_mon.operand_b)};
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: lcm=%0d gcd=%0d err=%0b",
                     out_mon.lcm_value, out_mon.gcd_value, out_mon.div_error);
          end
        end else begin
          exp_item = expected_q.pop_front();
          if (out_mon.lcm_value !== exp_item.lcm || out_mon.gcd_value !== exp_item.gcd ||
              out_mon.div_error !== exp_item.err) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch a=%0d b=%0d exp %0d/%0d/%0b got %0d/%0d/%0b",
                       exp_item.a, exp_item.b, exp_item.lcm, exp_item.gcd, exp_item.err,
                       out_mon.lcm_value, out_mon.gcd_value, out_mon.div_error);
            end
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_q.size();
  end

endmodule

FILE: verif/lcm_and_gcd_unit_tb.sv
module lcm_and_gcd_unit_tb;
  import lag_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n;
  logic hold_results;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   fail_count;
  int   pending;

  lag_in_if  in_ch ();
  lag_out_if out_ch ();

  lcm_and_gcd_unit #(.OPERAND_WIDTH(16)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lcm_gcd_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_results) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_operands(input logic [OperandPortWidth-1:0] a,
                               input logic [OperandPortWidth-1:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_operands(input int count);
    logic [OperandPortWidth-1:0] a;
    logic [OperandPortWidth-1:0] b;
    int                          g;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(5))
        0: begin
          a = OperandPortWidth'($urandom);
          b = OperandPortWidth'($urandom);
        end
        1: begin
          a = OperandPortWidth'($urandom_range(1, 60));
          b = OperandPortWidth'($urandom_range(1, 60));
        end
        2: begin
          g = $urandom_range(1, 255);
          a = OperandPortWidth'(g * $urandom_range(1, 255));
          b = OperandPortWidth'(g * $urandom_range(1, 255));
        end
        3: begin
          a = ($urandom_range(2) == 0) ? '0 : OperandPortWidth'($urandom);
          b = (a != '0 || $urandom_range(3) != 0) ? '0 : OperandPortWidth'($urandom);
          if ($urandom_range(1)) begin
            {a, b} = {b, a};
          end
        end
        4: begin
          a = OperandPortWidth'(($urandom_range(1, 15) | 1) << $urandom_range(12));
          b = OperandPortWidth'(($urandom_range(1, 15) | 1) << $urandom_range(12));
        end
        default: begin
          a = 16'hFFFF - OperandPortWidth'($urandom_range(300));
          b = 16'hFFFF - OperandPortWidth'($urandom_range(300));
        end
      endcase
      send_operands(a, b);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n           = 1'b0;
    hold_results    = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    snd_idle_pct    = 34;
    rcv_idle_pct    = 69;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_operands(16'h0000, 16'h0000);
    send_operands(16'h0000, 16'h0001);
    send_operands(16'h0001, 16'h0000);
    send_operands(16'h0000, 16'hFFFF);
    send_operands(16'hFFFF, 16'h0000);
    send_operands(16'h0001, 16'h0001);
    send_operands(16'h0001, 16'hFFFF);
    send_operands(16'hFFFF, 16'h0001);
    send_operands(16'hFFFF, 16'hFFFF);
    send_operands(16'hFFFF, 16'hFFFE);
    send_operands(16'hFFF1, 16'hFFEF);
    send_operands(16'd12, 16'd18);
    send_operands(16'd18, 16'd12);
    send_operands(16'h8000, 16'h8000);
    send_operands(16'h8000, 16'h4000);
    send_operands(16'hAAAA, 16'h5555);
    send_operands(16'h5555, 16'hAAAA);
    send_operands(16'd7, 16'd7);
    send_operands(16'd1000, 16'd999);
    send_random_operands(20);

    // receiver stalls while items keep coming, so the input backs up
    fork
      begin
        hold_results <= 1'b1;
        repeat (250) @(posedge clk);
        hold_results <= 1'b0;
      end
    join_none
    send_random_operands(8);
    drain_results();

    snd_idle_pct = 69;
    rcv_idle_pct = 34;
    send_random_operands(26);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_random_operands(27);

    drain_results();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: lcm_and_gcd_unit.f
design/lag_pkg.sv
design/lag_in_if.sv
design/lag_out_if.sv
design/lag_ctrl.sv
design/lag_dp.sv
design/lcm_and_gcd_unit.sv
verif/lcm_gcd_checker.sv
verif/lcm_and_gcd_unit_tb.sv
